>>> hdl/skt_pkg.sv
// Package for the sorted key table: beat structs, operation and status codes,
// cell control struct and the key normalization function.
// No dependencies.
`default_nettype none

package skt_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] key;
    logic [15:0] payload;
    logic [5:0]  position;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  where;
    logic [15:0] found_payload;
    logic [5:0]  entries;
  } out_beat_t;

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_SORTED_INS = 3'd0;
  localparam logic [2:0] MODE_INDEX_INS  = 3'd1;
  localparam logic [2:0] MODE_APPEND     = 3'd2;
  localparam logic [2:0] MODE_INDEX_DEL  = 3'd3;
  localparam logic [2:0] MODE_KEY_DEL    = 3'd4;
  localparam logic [2:0] MODE_SEARCH     = 3'd5;

  // Status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_COMPARE,
    OP_SCAN,
    OP_INSERT,
    OP_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     want_gt;  // compare for "stored key greater" instead of equality
  } cell_ctl_t;

  // Fold A..Z to lower case and clear every byte after the first zero byte,
  // so a plain unsigned compare orders keys case-insensitively.
  function automatic logic [63:0] norm_key(input logic [63:0] k);
    logic [63:0] r;
    logic        ended;
    logic [7:0]  c;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      c = k[63-8*i -: 8];
      if (c >= 8'h41 && c <= 8'h5A) begin
        c = c + 8'h20;
      end
      if (ended) begin
        c = 8'h00;
      end
      if (c == 8'h00) begin
        ended = 1'b1;
      end
      r[63-8*i -: 8] = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/skt_cell.sv
// One slot of the sorted key table: stored key and payload, compare flag,
// prefix-scan node and the shift logic toward both neighbors.
// Depends on skt_pkg.
`default_nettype none

module skt_cell
  import skt_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 6,
  parameter int KW  = 64,
  parameter int PW  = 16,
  parameter int LVN = 6
) (
  input  wire logic                    clk,
  input  wire cell_ctl_t               ctl_i,
  input  wire logic [LVN-1:0]          lvl_oh_i,
  input  wire logic [CW-1:0]           p_i,
  input  wire logic [CW-1:0]           count_i,
  input  wire logic [KW-1:0]           key_in_i,
  input  wire logic [PW-1:0]           pay_in_i,
  input  wire logic [KW-1:0]           left_key_i,
  input  wire logic [PW-1:0]           left_pay_i,
  input  wire logic [KW-1:0]           right_key_i,
  input  wire logic [PW-1:0]           right_pay_i,
  input  wire logic [LVN-1:0][1+CW+PW-1:0] nbr_i,
  output logic [KW-1:0]                key_o,
  output logic [PW-1:0]                pay_o,
  output logic [1+CW+PW-1:0]           node_o
);

  localparam int            NW = 1 + CW + PW;
  localparam logic [CW-1:0] ME = CW'(IDX);

  logic [KW-1:0] key_r, key_nxt;
  logic [PW-1:0] pay_r, pay_nxt;
  logic [NW-1:0] node_r, node_nxt;
  logic [NW-1:0] nb;
  logic          flag;

  // neighbor at the distance of the current scan level
  always_comb begin
    nb = '0;
    for (int k = 0; k < LVN; k++) begin
      if (lvl_oh_i[k]) begin
        nb = nbr_i[k];
      end
    end
  end

  assign flag = (ME < count_i) &&
                (ctl_i.want_gt ? (key_r > key_in_i) : (key_r == key_in_i));

  always_comb begin
    key_nxt  = key_r;
    pay_nxt  = pay_r;
    node_nxt = node_r;
    unique case (ctl_i.op)
      OP_COMPARE: node_nxt = {flag, ME, pay_r};
      OP_SCAN: begin
        // earlier hit wins
        if (nb[NW-1]) begin
          node_nxt = nb;
        end
      end
      OP_INSERT: begin
        if (ME == p_i) begin
          key_nxt = key_in_i;
          pay_nxt = pay_in_i;
        end else if (ME > p_i) begin
          key_nxt = left_key_i;
          pay_nxt = left_pay_i;
        end
      end
      OP_DELETE: begin
        if (ME >= p_i) begin
          key_nxt = right_key_i;
          pay_nxt = right_pay_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    pay_r  <= pay_nxt;
    node_r <= node_nxt;
  end

  assign key_o  = key_r;
  assign pay_o  = pay_r;
  assign node_o = node_r;

endmodule

`default_nettype wire

>>> hdl/sorted_key_table.sv
// Sorted key table, top level. Index ops (insert/append/delete at index) pass
// through accept, compare and decide; key ops (sorted insert, delete by key,
// search) also run the log-depth prefix scan across the cell row before the
// decide. One beat in flight: the next beat is taken only after the result is
// registered, and the decide waits while the output is stalled. Synchronous
// active-low reset empties the table; slot contents are not cleared.
`default_nettype none

module sorted_key_table
  import skt_pkg::*;
#(
  parameter int TABLE_SLOTS  = 64,
  parameter int KEY_CHARS    = 8,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_beat,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_beat
);

  // One cell per usable slot; a full table holds TABLE_SLOTS-1 entries.
  localparam int CELLS = TABLE_SLOTS - 1;
  localparam int CW    = $clog2(TABLE_SLOTS);
  localparam int KW    = KEY_CHARS * 8;
  localparam int PW    = PAYLOAD_BITS;
  localparam int LV    = $clog2(CELLS);        // prefix scan levels
  localparam int LVN   = (LV == 0) ? 1 : LV;
  localparam int LW    = $clog2(LVN + 1);
  localparam int NW    = 1 + CW + PW;          // scan node: {hit, index, payload}
  localparam int EW    = ((CW > 6) ? CW : 6) + 1;
  localparam int WW    = CW + 6;
  localparam int PX    = PW + 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [2:0]      mode_r, mode_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic [PW-1:0]   pay_r, pay_nxt;
  logic [5:0]      pos_r, pos_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_beat_t       out_beat_r, out_beat_nxt;

  cell_ctl_t       ctl;
  logic [LVN-1:0]  lvl_oh;
  logic [63:0]     in_key_norm;
  logic [PX-1:0]   in_pay_wide;

  logic [KW-1:0]   cell_key [CELLS];
  logic [PW-1:0]   cell_pay [CELLS];
  logic [NW-1:0]   node     [CELLS];

  // Result of the scan sits in the last cell: first hit over the whole row.
  logic            scan_hit;
  logic [CW-1:0]   scan_idx;
  logic [PW-1:0]   scan_pay;

  logic            full;
  logic [EW-1:0]   pos_e, cnt_e;
  logic [1:0]      dec_status;
  logic [CW-1:0]   dec_where;
  logic [PW-1:0]   dec_found;
  logic [CW-1:0]   dec_count;
  cell_op_t        dec_op;
  logic [WW-1:0]   where_wide, entries_wide;
  logic [PX-1:0]   found_wide;
  logic            finish_ok;
  logic            need_scan;

  assign in_key_norm = norm_key(in_beat.key);
  assign in_pay_wide = PX'(in_beat.payload);

  assign scan_hit = node[CELLS-1][NW-1];
  assign scan_idx = node[CELLS-1][PW +: CW];
  assign scan_pay = node[CELLS-1][PW-1:0];

  assign full  = (count_r == CW'(CELLS));
  assign pos_e = EW'(pos_r);
  assign cnt_e = EW'(count_r);

  // Decision for the held beat; the insert/delete position also goes to the
  // cells as p, so the shift happens on the same edge as the result write.
  always_comb begin
    dec_status = ST_DONE;
    dec_where  = '0;
    dec_found  = '0;
    dec_count  = count_r;
    dec_op     = OP_HOLD;
    unique case (mode_r)
      MODE_SORTED_INS: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_where = scan_hit ? scan_idx : count_r;
          dec_op    = OP_INSERT;
          dec_count = count_r + CW'(1);
        end
      end
      MODE_INDEX_INS: begin
        if (full) begin
          dec_status = ST_FULL;
        end else if (pos_e > cnt_e) begin
          dec_status = ST_BAD_INDEX;
        end else begin
          dec_where = pos_e[CW-1:0];
          dec_op    = OP_INSERT;
          dec_count = count_r + CW'(1);
        end
      end
      MODE_APPEND: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_where = count_r;
          dec_op    = OP_INSERT;
          dec_count = count_r + CW'(1);
        end
      end
      MODE_INDEX_DEL: begin
        if (pos_e >= cnt_e) begin
          dec_status = ST_BAD_INDEX;
        end else begin
          dec_where = pos_e[CW-1:0];
          dec_op    = OP_DELETE;
          dec_count = count_r - CW'(1);
        end
      end
      MODE_KEY_DEL: begin
        if (!scan_hit) begin
          dec_status = ST_NOT_FOUND;
        end else begin
          dec_where = scan_idx;
          dec_op    = OP_DELETE;
          dec_count = count_r - CW'(1);
        end
      end
      MODE_SEARCH: begin
        if (!scan_hit) begin
          dec_status = ST_NOT_FOUND;
        end else begin
          dec_where = scan_idx;
          dec_found = scan_pay;
        end
      end
      default: begin
        // unused modes: no change, done
      end
    endcase
  end

  assign where_wide   = WW'(dec_where);
  assign entries_wide = WW'(dec_count);
  assign found_wide   = PX'(dec_found);

  assign finish_ok = !(out_valid_r && out_stall);
  assign need_scan = (mode_r == MODE_SORTED_INS) || (mode_r == MODE_KEY_DEL) ||
                     (mode_r == MODE_SEARCH);
  assign lvl_oh    = LVN'(1) << lvl_r;

  // Sequencer: accept, compare in all cells, log-depth scan (key ops only), then apply.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    pos_nxt       = pos_r;
    lvl_nxt       = lvl_r;
    out_beat_nxt  = out_beat_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl.op        = OP_HOLD;
    ctl.want_gt   = (mode_r == MODE_SORTED_INS);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_beat.mode;
          key_nxt   = in_key_norm[63 -: KW];
          pay_nxt   = in_pay_wide[PW-1:0];
          pos_nxt   = in_beat.position;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctl.op    = OP_COMPARE;
        lvl_nxt   = '0;
        state_nxt = (need_scan && (LV != 0)) ? S_SCAN : S_DECIDE;
      end
      S_SCAN: begin
        ctl.op  = OP_SCAN;
        lvl_nxt = lvl_r + LW'(1);
        if (lvl_r == LW'(LV - 1)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // hold until the output register is free
        if (finish_ok) begin
          ctl.op                     = dec_op;
          count_nxt                  = dec_count;
          out_valid_nxt              = 1'b1;
          out_beat_nxt.status        = dec_status;
          out_beat_nxt.where         = where_wide[5:0];
          out_beat_nxt.found_payload = found_wide[15:0];
          out_beat_nxt.entries       = entries_wide[5:0];
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    pos_r      <= pos_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Cell row. Each cell sees its left and right neighbor for shifting and the
  // cells 1, 2, 4, ... places to its left for the prefix scan.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    localparam int LI = (i == 0) ? 0 : i - 1;
    localparam int RI = (i == CELLS - 1) ? i : i + 1;
    logic [LVN-1:0][NW-1:0] nbr;

    for (genvar k = 0; k < LVN; k++) begin : g_nbr
      if (k < LV && i >= (1 << k)) begin : g_on
        assign nbr[k] = node[i - (1 << k)];
      end else begin : g_off
        assign nbr[k] = '0;
      end
    end

    skt_cell #(
      .IDX (i),
      .CW  (CW),
      .KW  (KW),
      .PW  (PW),
      .LVN (LVN)
    ) u_cell (
      .clk         (clk),
      .ctl_i       (ctl),
      .lvl_oh_i    (lvl_oh),
      .p_i         (dec_where),
      .count_i     (count_r),
      .key_in_i    (key_r),
      .pay_in_i    (pay_r),
      .left_key_i  (cell_key[LI]),
      .left_pay_i  (cell_pay[LI]),
      .right_key_i (cell_key[RI]),
      .right_pay_i (cell_pay[RI]),
      .nbr_i       (nbr),
      .key_o       (cell_key[i]),
      .pay_o       (cell_pay[i]),
      .node_o      (node[i])
    );
  end

endmodule

`default_nettype wire
